[design/sparse_paged_byte_memory_defines.svh]
// ----------------------------------------------------------------------------
// Sparse paged byte memory: assertion macros
// Shared assertion wrappers; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef SPARSE_PAGED_BYTE_MEMORY_DEFINES_SVH
`define SPARSE_PAGED_BYTE_MEMORY_DEFINES_SVH

`ifndef SYNTHESIS

// Clocked property, disabled while reset is asserted.
`define SPBM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define SPBM_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define SPBM_ASSERT(label, clk, rst_n, prop, msg)
`define SPBM_ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

[design/spbm_pkg.sv]
// ----------------------------------------------------------------------------
// Sparse paged byte memory package
// Result codes and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package spbm_pkg;

    typedef enum logic [1:0] {
        ST_FOUND     = 2'd0,
        ST_ALLOCATED = 2'd1,
        ST_READ_MISS = 2'd2,
        ST_FULL      = 2'd3
    } status_code_t;

    typedef struct packed {
        logic         clr_en;    // write zero at the clear counter and advance it
        logic         capture;   // latch the accepted request
        logic         match;     // register the page-table compare vector
        logic         ram_rd;    // read the store at the selected slot
        logic         ram_wr;    // write the store at the selected slot
        logic         alloc;     // claim the next free slot for this page
        logic         load_out;  // load the result register
        status_code_t result;    // result code of the access
    } cmd_t;

    typedef struct packed {
        logic clr_last;  // clear counter is at the last entry
        logic hit;       // one valid slot holds the requested page
        logic full;      // every slot is allocated
        logic is_write;  // latched request is a write
        logic out_free;  // result register can take a new result
    } stat_t;

endpackage

[design/spbm_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One access per cycle; read data is registered and holds until the next read.
// ----------------------------------------------------------------------------
module spbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_reg[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/spbm_ctrl.sv]
// ----------------------------------------------------------------------------
// Sparse paged byte memory controller
// Sequences the clearing pass and the match, access and response steps.
// ----------------------------------------------------------------------------
module spbm_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  spbm_pkg::stat_t stat,
    output spbm_pkg::cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MATCH,
        S_ACCESS,
        S_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.result = spbm_pkg::ST_FOUND;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_en = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_MATCH;
                end
            end
            S_MATCH:
            begin
                cmd.match  = 1'b1;
                state_next = S_ACCESS;
            end
            S_ACCESS:
            begin
                if (!stat.is_write)
                begin
                    cmd.ram_rd = stat.hit;
                    cmd.result = stat.hit ? spbm_pkg::ST_FOUND : spbm_pkg::ST_READ_MISS;
                end
                else if (stat.hit)
                begin
                    cmd.ram_wr = 1'b1;
                    cmd.result = spbm_pkg::ST_FOUND;
                end
                else if (!stat.full)
                begin
                    cmd.ram_wr = 1'b1;
                    cmd.alloc  = 1'b1;
                    cmd.result = spbm_pkg::ST_ALLOCATED;
                end
                else
                begin
                    cmd.result = spbm_pkg::ST_FULL;
                end
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule

[design/spbm_datapath.sv]
// ----------------------------------------------------------------------------
// Sparse paged byte memory datapath
// Page table, match vector, slot selection, backing store and result register.
// ----------------------------------------------------------------------------
`include "sparse_paged_byte_memory_defines.svh"

module spbm_datapath #(
    parameter int MAX_PAGES  = 16,
    parameter int PAGE_BYTES = 256
) (
    input  logic            clk,
    input  logic            rst_n,
    input  spbm_pkg::cmd_t  cmd,
    output spbm_pkg::stat_t stat,
    input  logic            in_operation,
    input  logic [31:0]     in_address,
    input  logic [7:0]      in_write_data,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      out_read_data,
    output logic [1:0]      out_status
);

    localparam int OFF_W  = $clog2(PAGE_BYTES);
    localparam int PN_W   = 32 - OFF_W;
    localparam int SLOT_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int PU_W   = $clog2(MAX_PAGES + 1);
    localparam int DEPTH  = MAX_PAGES * PAGE_BYTES;
    localparam int RAM_AW = $clog2(DEPTH);

    // Latched request.
    logic             op_reg;
    logic [PN_W-1:0]  page_reg;
    logic [OFF_W-1:0] off_reg;
    logic [7:0]       wdata_reg;

    // Page table; entries are meaningful only below the fill count.
    logic [PN_W-1:0]  pt_reg [MAX_PAGES];
    logic [PU_W-1:0]  pages_used_reg;
    logic [MAX_PAGES-1:0] hit_reg;

    logic [RAM_AW-1:0] clr_cnt_reg;

    logic                 rd_sel_reg;
    spbm_pkg::status_code_t result_reg;
    logic                 out_valid_reg;
    logic [7:0]           out_data_reg;
    logic [1:0]           out_status_reg;

    logic [SLOT_W-1:0] hit_slot;
    logic [SLOT_W-1:0] slot_sel;
    logic [SLOT_W+OFF_W-1:0] acc_addr;
    logic              ram_en;
    logic              ram_we;
    logic [RAM_AW-1:0] ram_addr;
    logic [7:0]        ram_wdata;
    logic [7:0]        ram_rdata;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= in_operation;
            page_reg  <= in_address[31:OFF_W];
            off_reg   <= in_address[OFF_W-1:0];
            wdata_reg <= in_write_data;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_PAGES; i++)
        begin
            if (cmd.alloc && (slot_sel == SLOT_W'(i)))
            begin
                pt_reg[i] <= page_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pages_used_reg <= '0;
            hit_reg        <= '0;
            clr_cnt_reg    <= '0;
        end
        else
        begin
            if (cmd.alloc)
            begin
                pages_used_reg <= pages_used_reg + 1'b1;
            end
            if (cmd.match)
            begin
                for (int i = 0; i < MAX_PAGES; i++)
                begin
                    hit_reg[i] <= (PU_W'(i) < pages_used_reg) && (pt_reg[i] == page_reg);
                end
            end
            if (cmd.clr_en)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    // At most one slot can hold a page, so an OR of the indexes encodes the hit.
    always_comb
    begin
        hit_slot = '0;
        for (int i = 0; i < MAX_PAGES; i++)
        begin
            if (hit_reg[i])
            begin
                hit_slot = hit_slot | SLOT_W'(i);
            end
        end
    end

    assign slot_sel = cmd.alloc ? pages_used_reg[SLOT_W-1:0] : hit_slot;
    assign acc_addr = {slot_sel, off_reg};

    always_comb
    begin
        if (cmd.clr_en)
        begin
            ram_en    = 1'b1;
            ram_we    = 1'b1;
            ram_addr  = clr_cnt_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_en    = cmd.ram_rd | cmd.ram_wr;
            ram_we    = cmd.ram_wr;
            ram_addr  = acc_addr[RAM_AW-1:0];
            ram_wdata = wdata_reg;
        end
    end

    spbm_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.ram_rd || cmd.ram_wr || (cmd.result != spbm_pkg::ST_FOUND))
        begin
            rd_sel_reg <= cmd.ram_rd;
            result_reg <= cmd.result;
        end
        if (cmd.load_out)
        begin
            out_data_reg   <= rd_sel_reg ? ram_rdata : 8'h00;
            out_status_reg <= result_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign stat.clr_last = (clr_cnt_reg == RAM_AW'(DEPTH - 1));
    assign stat.hit      = |hit_reg;
    assign stat.full     = (pages_used_reg == PU_W'(MAX_PAGES));
    assign stat.is_write = op_reg;
    assign stat.out_free = !out_valid_reg || out_ready;

    assign out_valid     = out_valid_reg;
    assign out_read_data = out_data_reg;
    assign out_status    = out_status_reg;

    `SPBM_ASSERT(a_hit_unique, clk, rst_n, $onehot0(hit_reg),
                 "page held by more than one slot")
    `SPBM_ASSERT_NEVER(a_alloc_full, clk, rst_n, cmd.alloc && stat.full,
                       "allocation with a full table")
    `SPBM_ASSERT(a_alloc_count, clk, rst_n,
                 cmd.alloc |=> (pages_used_reg == PU_W'($past(pages_used_reg) + 1'b1)),
                 "fill count did not advance on allocation")
    `SPBM_ASSERT_NEVER(a_clear_access, clk, rst_n,
                       cmd.clr_en && (cmd.ram_rd || cmd.ram_wr || cmd.capture),
                       "access during clearing pass")

endmodule

[design/sparse_paged_byte_memory.sv]
// ----------------------------------------------------------------------------
// Sparse paged byte memory
// Allocate-on-write paged byte memory for an emulated 32-bit address space.
// ----------------------------------------------------------------------------
// Each input transfer is one byte read or write. The address space is split
// into aligned pages of PAGE_BYTES bytes (a power of two); the first write to
// a page claims the next free slot of the backing store, in order, up to
// MAX_PAGES slots. Reads of unmapped pages return 0 with a read-miss status;
// a write to a new page when all slots are taken is dropped and reported as
// table full. After reset the block clears its backing store, one byte per
// cycle, all MAX_PAGES * PAGE_BYTES bytes (4096 with the default sizes), and
// accepts no transfer until that pass ends. Each access then takes these steps
// from acceptance to the next acceptance: taking the request, registering the
// parallel page-table compare, the store access, and the registered store read
// reaching the result register. The result register lets a new request be
// accepted while a result still waits to be taken; the block stalls in its
// last step only if the previous result has not been taken by then.
module sparse_paged_byte_memory #(
    parameter int MAX_PAGES  = 16,
    parameter int PAGE_BYTES = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    // Request channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [31:0] address, [39:32] write_data
    input  logic        s_tuser,   // [0] operation (0 read, 1 write)
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] read_data
    output logic [1:0]  m_tuser    // [1:0] status
);

    spbm_pkg::cmd_t  cmd;
    spbm_pkg::stat_t stat;

    // The controller decides every step; the datapath only carries it out.
    spbm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Page table, slot selection, backing store and result register.
    spbm_datapath #(
        .MAX_PAGES  (MAX_PAGES),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .in_operation  (s_tuser),
        .in_address    (s_tdata[31:0]),
        .in_write_data (s_tdata[39:32]),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_read_data (m_tdata),
        .out_status    (m_tuser)
    );

endmodule
